>>> rtl/rct_pkg.sv
`timescale 1ns / 1ps

package rct_pkg;

  localparam int MaxCont = 16;
  localparam int IdBits  = 8;
  localparam int CntW    = $clog2(MaxCont + 1);

  localparam logic [31:0] VacuumReset = 32'h3F80_0000;

  typedef struct packed {
    logic [7:0]  object_id;
    logic [31:0] object_index;
    logic        is_hit;
    logic        last_item;
  } rct_item_t;

  typedef struct packed {
    logic [31:0] index_before;
    logic [31:0] index_after;
    logic        overflowed;
  } rct_result_t;

  // one list entry as held by a cell
  typedef struct packed {
    logic [IdBits-1:0] id;
    logic [31:0]       idx;
  } rct_entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic step;   // a transaction is accepted this cycle
    logic load;   // append lands in this cell
    logic valid;  // cell holds a live entry
  } rct_cell_ctl_t;

endpackage

>>> rtl/rct_cell.sv
`timescale 1ns / 1ps

module rct_cell import rct_pkg::*; (
  input  logic          clk_i,
  input  rct_cell_ctl_t ctl_i,
  input  logic          found_i,
  input  rct_entry_t    item_i,
  input  rct_entry_t    next_i,
  output logic          found_o,
  output logic          match_o,
  output rct_entry_t    entry_o
);

  rct_entry_t entry_q;

  assign match_o = ctl_i.valid && (entry_q.id == item_i.id);
  // once the removed entry is at or before this cell, pull from the neighbor
  assign found_o = found_i | match_o;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      if (found_o) begin
        entry_q <= next_i;
      end else if (ctl_i.load) begin
        entry_q <= item_i;
      end
    end
  end

endmodule

>>> rtl/refraction_container_tracker.sv
`timescale 1ns / 1ps

// Container list tracker for refraction: one intersection is taken every clock
// cycle (busy_o stays low) and a hit gives its n1/n2 result on result_o in the
// cycle after the start, marked by result_valid_o for that single cycle. There
// is no back-pressure on results: the receiver cannot stall and must take each
// result in the cycle it is shown. The list lives in a row of 16 cells that all
// compare the incoming id at once and close up in the same cycle, so nothing
// iterates. The vacuum index is written through the cfg channel, which is
// always ready.
module refraction_container_tracker import rct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  rct_item_t   item_i,
  output logic        result_valid_o,
  output rct_result_t result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     vacuum_q;
  logic            res_valid_q;
  rct_result_t     res_q;

  logic            accept;
  rct_entry_t      new_entry;
  rct_entry_t      entries [MaxCont];
  logic [MaxCont:0] found;
  logic [MaxCont-1:0] match;
  logic [MaxCont+1:0] vld;
  logic [MaxCont-1:0] is_top, is_second;
  logic [31:0]     top_val, second_val;
  logic            full, top_removed;
  logic [31:0]     before_val, after_val;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  assign new_entry.id  = item_i.object_id[IdBits-1:0];
  assign new_entry.idx = item_i.object_index;

  assign found[0] = 1'b0;
  assign vld[MaxCont+1:MaxCont] = 2'b00;

  for (genvar i = 0; i < MaxCont; i++) begin : g_cell
    rct_cell_ctl_t ctl;
    rct_entry_t    next_entry;

    assign vld[i]     = count_q > CntW'(i);
    assign ctl.step   = accept;
    assign ctl.valid  = vld[i];
    assign ctl.load   = !found[MaxCont] && (count_q == CntW'(i));
    if (i == MaxCont - 1) begin : g_end
      assign next_entry = entries[i];
    end else begin : g_mid
      assign next_entry = entries[i+1];
    end

    rct_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .found_i (found[i]),
      .item_i  (new_entry),
      .next_i  (next_entry),
      .found_o (found[i+1]),
      .match_o (match[i]),
      .entry_o (entries[i])
    );
  end

  // one-hot picks of the newest and second-newest entries
  always_comb begin
    top_val    = '0;
    second_val = '0;
    for (int i = 0; i < MaxCont; i++) begin
      is_top[i]    = vld[i] & ~vld[i+1];
      is_second[i] = vld[i+1] & ~vld[i+2];
      top_val      = top_val | ({32{is_top[i]}} & entries[i].idx);
      second_val   = second_val | ({32{is_second[i]}} & entries[i].idx);
    end
  end

  assign full        = count_q == CntW'(MaxCont);
  assign top_removed = |(match & is_top);
  assign before_val  = (count_q == '0) ? vacuum_q : top_val;

  always_comb begin
    priority if (found[MaxCont]) begin
      if (!top_removed) begin
        after_val = top_val;
      end else if (count_q > CntW'(1)) begin
        after_val = second_val;
      end else begin
        after_val = vacuum_q;
      end
    end else if (!full) begin
      after_val = new_entry.idx;
    end else begin
      after_val = before_val;
    end
  end

  always_comb begin
    ovf_d = ovf_q | (full & ~found[MaxCont]);
    priority if (found[MaxCont]) begin
      count_d = count_q - CntW'(1);
    end else if (!full) begin
      count_d = count_q + CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      vacuum_q    <= VacuumReset;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        vacuum_q <= cfg_data_i;
      end
      res_valid_q <= accept && item_i.is_hit;
      if (accept) begin
        if (item_i.last_item) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end else begin
          count_q <= count_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.is_hit) begin
      res_q.index_before <= before_val;
      res_q.index_after  <= after_val;
      res_q.overflowed   <= ovf_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxCont))
    else $error("container count beyond list depth");

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept && item_i.is_hit))
    else $error("result strobe without a hit transaction");

  a_ovf_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(full && accept && !found[MaxCont]))
    else $error("overflow flag set without a dropped append");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("id present twice in container list");

endmodule

>>> test/tb_refraction_container_tracker.sv
`timescale 1ns / 1ps

module tb_refraction_container_tracker;
  import rct_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  rct_item_t   item_i = '0;
  logic        result_valid_o;
  rct_result_t result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  refraction_container_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the container list
  logic [IdBits-1:0] inside_ids [MaxCont];
  logic [31:0]       inside_idx [MaxCont];
  int                inside_cnt = 0;
  logic              lost_entry = 1'b0;
  logic [31:0]       vacuum_bits = VacuumReset;

  rct_result_t expected_indices [$];

  int errors = 0;
  int items_sent = 0;
  int hits_checked = 0;
  int overflow_hits = 0;
  int vacuum_writes = 0;

  task automatic follow_intersection(input rct_item_t it);
    logic [IdBits-1:0] id;
    logic [31:0]       n1;
    int                pos;
    rct_result_t       res;
    id  = it.object_id[IdBits-1:0];
    n1  = (inside_cnt == 0) ? vacuum_bits : inside_idx[inside_cnt-1];
    pos = inside_cnt;
    for (int i = 0; i < inside_cnt; i++) begin
      if (pos == inside_cnt && inside_ids[i] == id) pos = i;
    end
    if (pos < inside_cnt) begin
      for (int i = pos; i + 1 < inside_cnt; i++) begin
        inside_ids[i] = inside_ids[i+1];
        inside_idx[i] = inside_idx[i+1];
      end
      inside_cnt--;
    end else if (inside_cnt < MaxCont) begin
      inside_ids[inside_cnt] = id;
      inside_idx[inside_cnt] = it.object_index;
      inside_cnt++;
    end else begin
      lost_entry = 1'b1;
    end
    if (it.is_hit) begin
      res.index_before = n1;
      res.index_after  = (inside_cnt == 0) ? vacuum_bits : inside_idx[inside_cnt-1];
      res.overflowed   = lost_entry;
      expected_indices.push_back(res);
    end
    if (it.last_item) begin
      inside_cnt = 0;
      lost_entry = 1'b0;
    end
  endtask

  // predict on every accepted transaction, then check any result of this cycle
  always @(posedge clk_i) begin
    rct_result_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) vacuum_bits = cfg_data_i;
      if (start_i && !busy_o) follow_intersection(item_i);
      if (result_valid_o) begin
        if (expected_indices.size() == 0) begin
          $error("result with nothing expected: n1=%h n2=%h ovf=%b",
                 result_o.index_before, result_o.index_after, result_o.overflowed);
          errors++;
        end else begin
          want = expected_indices.pop_front();
          hits_checked++;
          if (want.overflowed) overflow_hits++;
          if (result_o.index_before !== want.index_before) begin
            $error("index_before: expected %h, got %h", want.index_before,
                   result_o.index_before);
            errors++;
          end
          if (result_o.index_after !== want.index_after) begin
            $error("index_after: expected %h, got %h", want.index_after,
                   result_o.index_after);
            errors++;
          end
          if (result_o.overflowed !== want.overflowed) begin
            $error("overflowed: expected %b, got %b", want.overflowed,
                   result_o.overflowed);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] id, input logic [31:0] idx,
                           input logic hit, input logic last);
    int gap;
    rct_item_t it;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.object_id    = id;
    it.object_index = idx;
    it.is_hit       = hit;
    it.last_item    = last;
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  // stop issuing, let every pending result come out, then a few spare cycles
  task automatic wait_idle();
    int waited;
    waited = 0;
    start_i <= 1'b0;
    while (expected_indices.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_indices.size() != 0) begin
      $error("%0d expected results never arrived", expected_indices.size());
      errors++;
      expected_indices.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_vacuum(input logic [31:0] value);
    int gap;
    wait_idle();
    gap = $urandom_range(0, 6);
    repeat (gap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    vacuum_writes++;
  endtask

  // objects entered and left in overlapping order, random hit marks
  task automatic well_formed_ray(input int depth);
    logic [7:0]  obj_id  [24];
    logic [31:0] obj_idx [24];
    int          open_objs [$];
    int          next_obj;
    int          base;
    int          stride;
    int          pick;
    int          o;
    logic [31:0] idx;
    base     = $urandom_range(0, 255);
    stride   = 2 * $urandom_range(0, 127) + 1;
    next_obj = 0;
    for (int j = 0; j < depth; j++) begin
      obj_id[j]  = 8'((base + j * stride) % 256);
      obj_idx[j] = $urandom();
    end
    for (int e = 0; e < 2 * depth; e++) begin
      if (next_obj < depth && (open_objs.size() == 0 || $urandom_range(0, 1) == 1)) begin
        o = next_obj;
        next_obj++;
        open_objs.push_back(o);
        idx = obj_idx[o];
      end else begin
        pick = $urandom_range(0, open_objs.size() - 1);
        o = open_objs[pick];
        open_objs.delete(pick);
        // the index is ignored on exit, so vary it now and then
        idx = ($urandom_range(0, 3) == 0) ? $urandom() : obj_idx[o];
      end
      send_item(obj_id[o], idx, $urandom_range(0, 3) == 0, e == 2 * depth - 1);
    end
  endtask

  task automatic noise_ray();
    int          len;
    logic        narrow;
    logic [7:0]  id;
    len    = $urandom_range(1, 12);
    narrow = $urandom_range(0, 1);
    for (int e = 0; e < len; e++) begin
      id = narrow ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      send_item(id, $urandom(), $urandom_range(0, 1),
                (e == len - 1) && ($urandom_range(0, 7) != 0));
    end
  endtask

  task automatic test_empty_list();
    send_item(8'h00, 32'h0000_0000, 1'b1, 1'b0);
    send_item(8'h00, 32'h1234_5678, 1'b1, 1'b1);
  endtask

  task automatic test_nesting_and_removal();
    send_item(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(8'h01, 32'h3FC0_0000, 1'b0, 1'b0);
    send_item(8'h80, 32'h4000_0000, 1'b0, 1'b0);
    send_item(8'h01, 32'h0000_0000, 1'b1, 1'b0);  // leave the middle entry
    send_item(8'h7F, 32'h3F99_999A, 1'b1, 1'b0);
    send_item(8'h80, 32'h4000_0000, 1'b1, 1'b0);
    send_item(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(8'h7F, 32'h3F99_999A, 1'b1, 1'b1);
    // ray without a hit mark
    send_item(8'h10, 32'h4010_0000, 1'b0, 1'b0);
    send_item(8'h10, 32'h4010_0000, 1'b0, 1'b1);
  endtask

  task automatic test_overflow();
    for (int j = 0; j < MaxCont; j++) begin
      send_item(8'(j + 32), $urandom(), 1'b0, 1'b0);
    end
    send_item(8'hAA, 32'h4020_0000, 1'b1, 1'b0);  // dropped append
    send_item(8'd32, 32'h0, 1'b1, 1'b1);
    send_item(8'hAA, 32'h4020_0000, 1'b1, 1'b1);  // flag cleared by end of ray
  endtask

  task automatic test_vacuum_settings();
    logic [31:0] values [4];
    values[0] = 32'h0000_0000;
    values[1] = 32'hFFFF_FFFF;
    values[2] = $urandom();
    values[3] = VacuumReset;
    for (int v = 0; v < 4; v++) begin
      write_vacuum(values[v]);
      send_item(8'h05, $urandom(), 1'b1, 1'b0);
      send_item(8'h05, $urandom(), 1'b1, 1'b1);
    end
  endtask

  task automatic test_random_rays(input int target);
    int next_cfg;
    next_cfg = items_sent + 250;
    while (items_sent < target) begin
      if (items_sent >= next_cfg) begin
        case ($urandom_range(0, 3))
          0: write_vacuum(32'h0000_0000);
          1: write_vacuum(32'hFFFF_FFFF);
          default: write_vacuum($urandom());
        endcase
        next_cfg = items_sent + 250;
      end
      if ($urandom_range(0, 4) == 0) noise_ray();
      else if ($urandom_range(0, 15) == 0) well_formed_ray($urandom_range(MaxCont - 1, 22));
      else well_formed_ray($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_nesting_and_removal();
    test_overflow();
    test_vacuum_settings();
    test_random_rays(1500);
    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("ran %0d intersections, checked %0d hit results (%0d with overflow)",
             items_sent, hits_checked, overflow_hits);
    $display("vacuum index rewritten %0d times, extremes included", vacuum_writes);
    if (errors == 0) begin
      $display("refraction_container_tracker verification clean");
    end else begin
      $display("refraction_container_tracker verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("refraction_container_tracker verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/rct_pkg.sv
rtl/rct_cell.sv
rtl/refraction_container_tracker.sv
test/tb_refraction_container_tracker.sv
